// File: hdl/divider_and_reload_timer_assert.svh
// Assertion macros for the divider and reload timer checker.
// Used by hdl/drt_checker.sv; no other dependencies.
`ifndef DIVIDER_AND_RELOAD_TIMER_ASSERT_SVH
`define DIVIDER_AND_RELOAD_TIMER_ASSERT_SVH

// Check a property on every clock edge outside reset
`define DRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define DRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/drt_pkg.sv
// Shared types and constants for the divider and reload timer.
// No dependencies; imported by drt_core, divider_and_reload_timer and the testbench.
package drt_pkg;

    // Default number of ticks per divider step
    localparam int unsigned DIVIDER_PERIOD_DEF = 64;

    localparam int unsigned CTRL_ENABLE_BIT = 2;
    localparam logic [7:0]  COUNTER_MAX     = 8'hFF;
    localparam int unsigned CPS_W           = 9;

    // Counter period per control bits 1..0
    localparam logic [CPS_W-1:0] PERIOD_TABLE [4] = '{9'd256, 9'd4, 9'd16, 9'd64};

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } t_req_kind;

    typedef enum logic [1:0] {
        OFS_DIVIDER = 2'd0,
        OFS_COUNTER = 2'd1,
        OFS_MODULO  = 2'd2,
        OFS_CONTROL = 2'd3
    } t_reg_ofs;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] reg_offset;
        logic [7:0] write_data;
    } t_req;

    typedef struct packed {
        logic       timer_irq;
        logic [7:0] read_data;
    } t_rsp;

endpackage

// File: hdl/drt_core.sv
// Timer register file and single-pass tick/read/write logic.
// Depends on drt_pkg.
module drt_core #(
    parameter int unsigned DIVIDER_PERIOD = drt_pkg::DIVIDER_PERIOD_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  drt_pkg::t_req i_req,
    output drt_pkg::t_rsp o_rsp
);
    import drt_pkg::*;

    localparam int unsigned DivPsW = $clog2(DIVIDER_PERIOD + 1);
    localparam logic [DivPsW-1:0] DivLimit = DivPsW'(DIVIDER_PERIOD);

    logic [7:0]        r_div_val, n_div_val;
    logic [DivPsW-1:0] r_div_ps,  n_div_ps;
    logic [7:0]        r_cnt,     n_cnt;
    logic [7:0]        r_mod,     n_mod;
    logic [7:0]        r_ctrl,    n_ctrl;
    logic [CPS_W-1:0]  r_cps,     n_cps;
    logic [1:0]        r_per_sel, n_per_sel;

    logic [DivPsW-1:0] w_div_inc;
    logic [CPS_W-1:0]  w_cps_inc;
    t_rsp              w_rsp;

    assign w_div_inc = r_div_ps + DivPsW'(1);
    assign w_cps_inc = r_cps + CPS_W'(1);

    // Work out the next timer state and the response for the current request
    always_comb begin
        n_div_val = r_div_val;
        n_div_ps  = r_div_ps;
        n_cnt     = r_cnt;
        n_mod     = r_mod;
        n_ctrl    = r_ctrl;
        n_cps     = r_cps;
        n_per_sel = r_per_sel;
        w_rsp     = '0;
        case (i_req.req_type)
            REQ_TICK: begin
                // Advance the free-running divider
                if (w_div_inc >= DivLimit) begin
                    n_div_val = r_div_val + 8'd1;
                    n_div_ps  = '0;
                end else begin
                    n_div_ps  = w_div_inc;
                end
                // Advance the counter while enabled; reload and flag on overflow
                if (r_ctrl[CTRL_ENABLE_BIT]) begin
                    if (w_cps_inc >= PERIOD_TABLE[r_per_sel]) begin
                        n_cps = '0;
                        if (r_cnt == COUNTER_MAX) begin
                            n_cnt           = r_mod;
                            w_rsp.timer_irq = 1'b1;
                        end else begin
                            n_cnt = r_cnt + 8'd1;
                        end
                    end else begin
                        n_cps = w_cps_inc;
                    end
                end
            end
            REQ_READ: begin
                case (i_req.reg_offset)
                    OFS_DIVIDER: w_rsp.read_data = r_div_val;
                    OFS_COUNTER: w_rsp.read_data = r_cnt;
                    OFS_MODULO:  w_rsp.read_data = r_mod;
                    default:     w_rsp.read_data = r_ctrl;
                endcase
            end
            REQ_WRITE: begin
                case (i_req.reg_offset)
                    OFS_DIVIDER: begin
                        n_div_val = '0;
                        n_div_ps  = '0;
                    end
                    OFS_COUNTER: n_cnt = i_req.write_data;
                    OFS_MODULO:  n_mod = i_req.write_data;
                    default: begin
                        n_ctrl = i_req.write_data;
                        // Keep the old period when the write leaves the timer disabled
                        if (i_req.write_data[CTRL_ENABLE_BIT]) begin
                            n_per_sel = i_req.write_data[1:0];
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Commit the state when the request moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_val <= '0;
            r_div_ps  <= '0;
            r_cnt     <= '0;
            r_mod     <= '0;
            r_ctrl    <= '0;
            r_cps     <= '0;
            r_per_sel <= '0;
        end else if (i_step) begin
            r_div_val <= n_div_val;
            r_div_ps  <= n_div_ps;
            r_cnt     <= n_cnt;
            r_mod     <= n_mod;
            r_ctrl    <= n_ctrl;
            r_cps     <= n_cps;
            r_per_sel <= n_per_sel;
        end
    end

    assign o_rsp = w_rsp;

endmodule

// File: hdl/divider_and_reload_timer.sv
// Divider and reload timer: one tick, read or write request per cycle.
// The input register holds a request; the result register holds its response.
// Throughput: one request per cycle while m_axis_tready stays high; the input
// register and the result register each hold one request.
// Reset (synchronous, i_rst_n low): all timer registers clear, period 256 ticks.
// Depends on drt_pkg and drt_core.
module divider_and_reload_timer #(
    parameter int unsigned DIVIDER_PERIOD = drt_pkg::DIVIDER_PERIOD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [1:0] reg_offset, [9:2] write_data, [15:10] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [7:0] read_data, [8] timer_irq, [15:9] zero
);
    import drt_pkg::*;

    logic r_in_valid,  n_in_valid;
    logic r_out_valid, n_out_valid;
    t_req r_in;
    t_rsp r_out;
    t_rsp w_rsp;
    logic w_acc;
    logic w_adv;

    // Move the held request forward when the result register is free or draining
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign n_in_valid  = w_acc || (r_in_valid && !w_adv);
    assign n_out_valid = w_adv || (r_out_valid && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the request and the response
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in.req_type   <= s_axis_tuser;
            r_in.reg_offset <= s_axis_tdata[1:0];
            r_in.write_data <= s_axis_tdata[9:2];
        end
        if (w_adv) begin
            r_out <= w_rsp;
        end
    end

    drt_core #(
        .DIVIDER_PERIOD(DIVIDER_PERIOD)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (w_adv),
        .i_req  (r_in),
        .o_rsp  (w_rsp)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.timer_irq, r_out.read_data};

endmodule

// File: hdl/drt_checker.sv
// Port-level checks for divider_and_reload_timer, attached by bind.
// Depends on divider_and_reload_timer_assert.svh.
`include "divider_and_reload_timer_assert.svh"

module drt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    property p_hold;
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
    endproperty

    property p_stall_cause;
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready;
    endproperty

    property p_irq_no_data;
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0;
    endproperty

    // Drop any pending response on reset
    `DRT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !m_axis_tvalid, "response after reset")

    // Hold a stalled response
    `DRT_ASSERT(a_hold, i_clk, i_rst_n, p_hold, "stalled response changed")

    // Backpressure upstream only while the output is stalled
    `DRT_ASSERT(a_stall_cause, i_clk, i_rst_n, p_stall_cause, "request stalled, no output stall")

    // An interrupt comes from a tick, which returns no read data
    `DRT_ASSERT(a_irq_no_data, i_clk, i_rst_n, p_irq_no_data, "irq with read data")

endmodule

bind divider_and_reload_timer drt_checker u_drt_checker (.*);

// File: dv/tb_divider_and_reload_timer.sv
// Self-checking testbench for divider_and_reload_timer: drives ticks, reads and writes,
// predicts each response from its own timer state and compares the result stream.
// Depends on drt_pkg and the divider_and_reload_timer RTL.
module tb_divider_and_reload_timer;
    import drt_pkg::*;

    // Request type that the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned RANDOM_REQS = 600;

    typedef struct {
        logic [1:0] kind;
        logic [1:0] ofs;
        logic [7:0] data;
        bit         drain;  // hold this request until every response has come
    } t_timer_req;

    typedef struct {
        logic [7:0] rd;
        logic       irq;
    } t_timer_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [1:0] reg_offset, [9:2] write_data, [15:10] zero
    logic [1:0]  s_axis_tuser = '0;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [7:0] read_data, [8] timer_irq, [15:9] zero

    t_timer_req  req_pending[$];
    t_timer_rsp  rsp_expected[$];
    t_timer_req  tx_cur;
    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;
    int unsigned tx_calm = 0;
    int unsigned rx_calm = 0;
    int unsigned n_errors = 0;

    // Predicted timer state
    logic [7:0] tm_div;
    logic [6:0] tm_div_pre;
    logic [7:0] tm_cnt;
    logic [7:0] tm_mod;
    logic [7:0] tm_ctl;
    logic [8:0] tm_cnt_pre;
    logic [8:0] tm_period;

    divider_and_reload_timer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advance the predicted timer by one request and return its response
    task automatic timer_step(input logic [1:0] kind, input logic [1:0] ofs,
                              input logic [7:0] data, output t_timer_rsp rsp);
        rsp.rd  = 8'h00;
        rsp.irq = 1'b0;
        if (kind == REQ_TICK) begin
            tm_div_pre = tm_div_pre + 7'd1;
            if (tm_div_pre >= DIVIDER_PERIOD_DEF) begin
                tm_div     = tm_div + 8'd1;
                tm_div_pre = '0;
            end
            if (tm_ctl[CTRL_ENABLE_BIT]) begin
                tm_cnt_pre = tm_cnt_pre + 9'd1;
                if (tm_cnt_pre >= tm_period) begin
                    tm_cnt_pre = '0;
                    if (tm_cnt == COUNTER_MAX) begin
                        tm_cnt  = tm_mod;
                        rsp.irq = 1'b1;
                    end else begin
                        tm_cnt = tm_cnt + 8'd1;
                    end
                end
            end
        end else if (kind == REQ_READ) begin
            case (ofs)
                OFS_DIVIDER: rsp.rd = tm_div;
                OFS_COUNTER: rsp.rd = tm_cnt;
                OFS_MODULO:  rsp.rd = tm_mod;
                default:     rsp.rd = tm_ctl;
            endcase
        end else if (kind == REQ_WRITE) begin
            case (ofs)
                OFS_DIVIDER: begin
                    tm_div     = '0;
                    tm_div_pre = '0;
                end
                OFS_COUNTER: tm_cnt = data;
                OFS_MODULO:  tm_mod = data;
                default: begin
                    tm_ctl = data;
                    if (data[CTRL_ENABLE_BIT])
                        tm_period = PERIOD_TABLE[data[1:0]];
                end
            endcase
        end
    endtask

    // Wait before the next request or response: calm stretches with none, else 0..16
    function automatic int unsigned pick_wait(inout int unsigned calm);
        if (calm != 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm = $urandom_range(20, 40);
        return $urandom_range(0, 16);
    endfunction

    task automatic add_req(input logic [1:0] kind, input logic [1:0] ofs,
                           input logic [7:0] data, input bit drain = 1'b0);
        t_timer_req r;
        r.kind  = kind;
        r.ofs   = ofs;
        r.data  = data;
        r.drain = drain;
        req_pending.push_back(r);
    endtask

    // Mostly ticks, with reads, writes and the odd unused request type
    task automatic add_random_req(input bit drain);
        int unsigned pick;
        logic [1:0]  kind;
        logic [1:0]  ofs;
        logic [7:0]  data;
        pick = $urandom_range(0, 99);
        ofs  = 2'($urandom_range(0, 3));
        data = 8'($urandom_range(0, 255));
        if (pick < 68)
            kind = REQ_TICK;
        else if (pick < 82)
            kind = REQ_READ;
        else if (pick < 97)
            kind = REQ_WRITE;
        else
            kind = REQ_UNUSED;
        if (kind == REQ_WRITE) begin
            // Keep the counter near overflow and the timer mostly enabled
            if (ofs == OFS_COUNTER && $urandom_range(0, 1) == 1)
                data = 8'($urandom_range(8'hF0, 8'hFF));
            if (ofs == OFS_CONTROL && $urandom_range(0, 3) != 0)
                data[CTRL_ENABLE_BIT] = 1'b1;
        end
        add_req(kind, ofs, data, drain);
    endtask

    // Drive requests and predict each one as it is accepted
    always @(posedge i_clk) begin : drive_proc
        t_timer_rsp rsp;
        t_timer_req req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_wait       <= 0;
            tm_div        = '0;
            tm_div_pre    = '0;
            tm_cnt        = '0;
            tm_mod        = '0;
            tm_ctl        = '0;
            tm_cnt_pre    = '0;
            tm_period     = 9'd256;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                timer_step(tx_cur.kind, tx_cur.ofs, tx_cur.data, rsp);
                rsp_expected.push_back(rsp);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_wait != 0) begin
                    s_axis_tvalid <= 1'b0;
                    tx_wait       <= tx_wait - 1;
                end else if (req_pending.size() != 0 &&
                             !(req_pending[0].drain && rsp_expected.size() != 0)) begin
                    req = req_pending.pop_front();
                    tx_cur        <= req;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, req.data, req.ofs};
                    s_axis_tuser  <= req.kind;
                    tx_wait       <= pick_wait(tx_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Accept responses with random stalls and check them in order
    always @(posedge i_clk) begin : check_proc
        t_timer_rsp exp_rsp;
        int unsigned nxt;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (rsp_expected.size() == 0) begin
                $error("response with no request outstanding: read_data %02h timer_irq %0b",
                       m_axis_tdata[7:0], m_axis_tdata[8]);
                n_errors++;
            end else begin
                exp_rsp = rsp_expected.pop_front();
                if (m_axis_tdata[7:0] !== exp_rsp.rd) begin
                    $error("read_data: expected %02h, got %02h", exp_rsp.rd, m_axis_tdata[7:0]);
                    n_errors++;
                end
                if (m_axis_tdata[8] !== exp_rsp.irq) begin
                    $error("timer_irq: expected %0b, got %0b", exp_rsp.irq, m_axis_tdata[8]);
                    n_errors++;
                end
            end
            nxt = pick_wait(rx_calm);
            rx_wait       <= nxt;
            m_axis_tready <= (nxt == 0);
        end else if (rx_wait != 0) begin
            rx_wait       <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        int unsigned drain_a;
        int unsigned drain_b;

        // Reset values of every register
        add_req(REQ_READ, OFS_DIVIDER, 8'h00);
        add_req(REQ_READ, OFS_COUNTER, 8'hFF);
        add_req(REQ_READ, OFS_MODULO,  8'h00);
        add_req(REQ_READ, OFS_CONTROL, 8'hFF);
        // Counter at its top with period 4: the fourth tick reloads and raises the irq
        add_req(REQ_WRITE, OFS_MODULO,  8'hA5);
        add_req(REQ_WRITE, OFS_COUNTER, 8'hFF);
        add_req(REQ_WRITE, OFS_CONTROL, 8'h05);
        repeat (4) add_req(REQ_TICK, OFS_DIVIDER, 8'h00);
        add_req(REQ_READ, OFS_COUNTER, 8'h00);
        // Period shortened below the prescaler: the counter steps on the next tick
        add_req(REQ_WRITE, OFS_CONTROL, 8'h04);
        repeat (5) add_req(REQ_TICK, OFS_CONTROL, 8'hFF);
        add_req(REQ_WRITE, OFS_CONTROL, 8'h05);
        add_req(REQ_TICK, OFS_COUNTER, 8'h00);
        add_req(REQ_READ, OFS_COUNTER, 8'h00);
        // Enable clear keeps the old period and stops the counter
        add_req(REQ_WRITE, OFS_CONTROL, 8'hFB);
        add_req(REQ_TICK, OFS_MODULO, 8'h00);
        add_req(REQ_READ, OFS_CONTROL, 8'h00);
        // Divider clear ignores the data byte
        add_req(REQ_WRITE, OFS_DIVIDER, 8'hFF);
        add_req(REQ_READ, OFS_DIVIDER, 8'h00);
        // Unused request type
        add_req(REQ_UNUSED, OFS_CONTROL, 8'hFF);
        add_req(REQ_WRITE, OFS_CONTROL, 8'h07);

        drain_a = $urandom_range(100, 250);
        drain_b = $urandom_range(350, 500);
        for (int unsigned n = 0; n < RANDOM_REQS; n++)
            add_random_req(n == drain_a || n == drain_b);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_pending.size() != 0 || s_axis_tvalid || rsp_expected.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_divider_and_reload_timer: done, clean");
        else
            $display("tb_divider_and_reload_timer: done, errors");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2000000;
        $display("tb_divider_and_reload_timer: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/drt_pkg.sv
hdl/drt_core.sv
hdl/divider_and_reload_timer.sv
hdl/drt_checker.sv
dv/tb_divider_and_reload_timer.sv
